[design/tdne_pkg.sv]
package tdne_pkg;

  // field and digit widths
  localparam int unsigned TAG_W      = 64;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIG_IDX_W  = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned HDR_BYTES  = 8;

  // largest magnitude of a delta that is still coded
  localparam logic [TAG_W-1:0] DELTA_LIMIT     = 64'd10000000000000000;
  // two's-complement image of the negative limit
  localparam logic [TAG_W-1:0] NEG_DELTA_LIMIT = 64'(~DELTA_LIMIT + 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_SUB,
    ST_EMIT,
    ST_ERR
  } tdne_state_e;

  // running status of the digit-serial difference scan
  typedef struct packed {
    logic             borrow;
    logic             above_lim;
    logic             below_neg;
    logic [LEN_W-1:0] len_pos;
    logic [LEN_W-1:0] len_neg;
  } tdne_scan_t;

endpackage

[design/tdne_tag_if.sv]
interface tdne_tag_if import tdne_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TAG_W-1:0] timestamp;
  logic                    first_of_block;
  logic                    last_of_block;

  modport source (output valid, timestamp, first_of_block, last_of_block, input ready);
  modport sink   (input valid, timestamp, first_of_block, last_of_block, output ready);
endinterface

[design/tdne_byte_if.sv]
interface tdne_byte_if import tdne_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_run;
  logic              end_of_block;
  logic              delta_error;

  modport source (output valid, out_byte, end_of_run, end_of_block, delta_error, input ready);
  modport sink   (input valid, out_byte, end_of_run, end_of_block, delta_error, output ready);
endinterface

[design/tdne_digit_step.sv]
module tdne_digit_step import tdne_pkg::*; (
  input  logic [DIGIT_W-1:0]   tag_dig_i,
  input  logic [DIGIT_W-1:0]   prev_dig_i,
  input  logic [DIG_IDX_W-1:0] idx_i,
  input  tdne_scan_t           scan_i,
  output logic [DIGIT_W-1:0]   diff_dig_o,
  output tdne_scan_t           scan_o
);

  logic [DIGIT_W:0]   diff;
  logic [DIGIT_W-1:0] lim_dig;
  logic [DIGIT_W-1:0] neg_dig;
  logic [LEN_W-1:0]   need_lo;
  logic [LEN_W-1:0]   need_hi;

  // one nibble of tag minus previous tag, with borrow
  assign diff = {1'b0, tag_dig_i} - {1'b0, prev_dig_i} - {{DIGIT_W{1'b0}}, scan_i.borrow};
  assign diff_dig_o = diff[DIGIT_W-1:0];

  // matching nibbles of both limits
  assign lim_dig = DELTA_LIMIT[{idx_i, 2'b00} +: DIGIT_W];
  assign neg_dig = NEG_DELTA_LIMIT[{idx_i, 2'b00} +: DIGIT_W];

  // length needed if this nibble breaks the sign extension
  assign need_lo = LEN_W'({1'b0, idx_i}) + LEN_W'(1);
  assign need_hi = LEN_W'({1'b0, idx_i}) + LEN_W'(2);

  // update borrow, limit compares (LSB first) and length trackers
  always_comb begin
    scan_o        = scan_i;
    scan_o.borrow = diff[DIGIT_W];
    if (diff_dig_o > lim_dig) begin
      scan_o.above_lim = 1'b1;
    end else if (diff_dig_o < lim_dig) begin
      scan_o.above_lim = 1'b0;
    end
    if (diff_dig_o < neg_dig) begin
      scan_o.below_neg = 1'b1;
    end else if (diff_dig_o > neg_dig) begin
      scan_o.below_neg = 1'b0;
    end
    // assuming a positive delta
    if (diff_dig_o[3]) begin
      scan_o.len_pos = need_hi;
    end else if (diff_dig_o[2:0] != 3'b000) begin
      scan_o.len_pos = need_lo;
    end
    // assuming a negative delta
    if (!diff_dig_o[3]) begin
      scan_o.len_neg = need_hi;
    end else if (diff_dig_o[2:0] != 3'b111) begin
      scan_o.len_neg = need_lo;
    end
  end

endmodule

[design/timestamp_delta_nibble_encoder_core.sv]
// Time tag delta encoder.
// Requests arrive on tag_in_i (timestamp, first_of_block, last_of_block) and
// encoded bytes leave on byte_out_o, both valid/ready channels.
// One request is handled at a time; tag_in_i.ready is high only while idle.
// A first_of_block request sends the tag as 8 bytes, MSB first, one byte per
// cycle while the output register is free.
// Any other request runs a nibble-serial subtract and range scan over all 16
// nibbles, then streams the length nibble and L delta nibbles at one nibble
// per cycle while the output register is free, plus a flush of a half byte
// at the end of a block; L = 1..14.
// An out-of-range delta gives one error byte and the block is dropped until
// the next first_of_block; requests in a dropped block are taken with no bytes.
// The output register holds a byte until byte_out_o.ready; while it is full
// and not taken, the byte-sending states stall in place and no byte is lost.
// Reset (rst_ni low) clears the pending half byte, the abort flag and the
// output valid; the stored previous tag is only defined after a block start.
module timestamp_delta_nibble_encoder_core import tdne_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdne_tag_if.sink     tag_in_i,
  tdne_byte_if.source  byte_out_o
);

  tdne_state_e state_q, state_d;

  logic [DIG_IDX_W-1:0] cnt_q, cnt_d;
  logic [TAG_W-1:0]     sh_q, sh_d;
  logic [TAG_W-1:0]     prev_q, prev_d;
  logic [TAG_W-1:0]     dlt_q, dlt_d;
  tdne_scan_t           scan_q, scan_d;
  logic [DIGIT_W-1:0]   len_q, len_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic                 last_q, last_d;
  logic                 pend_q, pend_d;
  logic [DIGIT_W-1:0]   pnib_q, pnib_d;
  logic                 abort_q, abort_d;

  logic                 ov_q, ov_d;
  logic [BYTE_W-1:0]    ob_q, ob_d;
  logic                 eor_q, eor_d;
  logic                 eob_q, eob_d;
  logic                 err_q, err_d;

  logic                 accept;
  logic                 out_free;
  logic [DIGIT_W-1:0]   diff_dig;
  tdne_scan_t           scan_nx;
  logic                 neg_fin;
  logic                 err_fin;
  logic [DIGIT_W-1:0]   len_fin;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [DIGIT_W-1:0]   nib;

  assign tag_in_i.ready = (state_q == ST_IDLE);
  assign accept         = tag_in_i.valid && tag_in_i.ready;
  assign out_free       = !ov_q || byte_out_o.ready;

  // one digit of the difference per cycle, LSB first
  tdne_digit_step u_step (
    .tag_dig_i  (sh_q[DIGIT_W-1:0]),
    .prev_dig_i (prev_q[DIGIT_W-1:0]),
    .idx_i      (cnt_q),
    .scan_i     (scan_q),
    .diff_dig_o (diff_dig),
    .scan_o     (scan_nx)
  );

  // verdict on the last digit of the scan
  assign neg_fin = diff_dig[3];
  assign err_fin = neg_fin ? scan_nx.below_neg : scan_nx.above_lim;
  assign len_fin = neg_fin ? scan_nx.len_neg[DIGIT_W-1:0] : scan_nx.len_pos[DIGIT_W-1:0];

  // next nibble of the delta code
  assign dig_idx = rem_q - DIG_IDX_W'(1);
  assign nib     = (rem_q == DIGIT_W'(len_q + DIGIT_W'(1))) ? len_q
                                                             : dlt_q[{dig_idx, 2'b00} +: DIGIT_W];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (tag_in_i.first_of_block) begin
            state_d = ST_HDR;
          end else if (!abort_q) begin
            state_d = ST_SUB;
          end
        end
      end
      ST_HDR: begin
        if (out_free && cnt_q == DIG_IDX_W'(HDR_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SUB: begin
        if (cnt_q == '1) begin
          state_d = err_fin ? ST_ERR : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (rem_q == '0) begin
            state_d = ST_IDLE;
          end else if (rem_q == DIGIT_W'(1) && (pend_q || !last_q)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register loads
  always_comb begin
    cnt_d   = cnt_q;
    sh_d    = sh_q;
    prev_d  = prev_q;
    dlt_d   = dlt_q;
    scan_d  = scan_q;
    len_d   = len_q;
    rem_d   = rem_q;
    last_d  = last_q;
    pend_d  = pend_q;
    pnib_d  = pnib_q;
    abort_d = abort_q;
    ov_d    = ov_q && !byte_out_o.ready;
    ob_d    = ob_q;
    eor_d   = eor_q;
    eob_d   = eob_q;
    err_d   = err_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sh_d   = tag_in_i.timestamp;
          last_d = tag_in_i.last_of_block;
          cnt_d  = '0;
          scan_d = '{borrow: 1'b0, above_lim: 1'b0, below_neg: 1'b0,
                     len_pos: LEN_W'(1), len_neg: LEN_W'(1)};
          if (tag_in_i.first_of_block) begin
            prev_d  = tag_in_i.timestamp;
            pend_d  = 1'b0;
            pnib_d  = '0;
            abort_d = 1'b0;
          end
        end
      end
      ST_HDR: begin
        // header byte, MSB first
        if (out_free) begin
          ov_d  = 1'b1;
          ob_d  = sh_q[TAG_W-1 -: BYTE_W];
          eor_d = (cnt_q == DIG_IDX_W'(HDR_BYTES - 1));
          eob_d = (cnt_q == DIG_IDX_W'(HDR_BYTES - 1)) && last_q;
          err_d = 1'b0;
          sh_d  = sh_q << BYTE_W;
          cnt_d = cnt_q + DIG_IDX_W'(1);
        end
      end
      ST_SUB: begin
        // tag rotates into the previous-tag register as the delta builds up
        sh_d   = sh_q >> DIGIT_W;
        prev_d = {sh_q[DIGIT_W-1:0], prev_q[TAG_W-1:DIGIT_W]};
        dlt_d  = {diff_dig, dlt_q[TAG_W-1:DIGIT_W]};
        scan_d = scan_nx;
        cnt_d  = cnt_q + DIG_IDX_W'(1);
        if (cnt_q == '1) begin
          len_d = len_fin;
          rem_d = len_fin + DIGIT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (rem_q == '0) begin
            // flush the half byte at block end
            ov_d   = 1'b1;
            ob_d   = {pnib_q, 4'h0};
            eor_d  = 1'b1;
            eob_d  = 1'b1;
            err_d  = 1'b0;
            pend_d = 1'b0;
            pnib_d = '0;
          end else begin
            rem_d = rem_q - DIGIT_W'(1);
            if (pend_q) begin
              ov_d   = 1'b1;
              ob_d   = {pnib_q, nib};
              eor_d  = (rem_q == DIGIT_W'(1)) || (rem_q == DIGIT_W'(2) && !last_q);
              eob_d  = ((rem_q == DIGIT_W'(1)) || (rem_q == DIGIT_W'(2) && !last_q))
                       && last_q;
              err_d  = 1'b0;
              pend_d = 1'b0;
              pnib_d = '0;
            end else begin
              pend_d = 1'b1;
              pnib_d = nib;
            end
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ob_d    = '0;
          eor_d   = 1'b1;
          eob_d   = 1'b1;
          err_d   = 1'b1;
          abort_d = 1'b1;
          pend_d  = 1'b0;
          pnib_d  = '0;
        end
      end
      default: begin
        ov_d = ov_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      pnib_q  <= '0;
      abort_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      pnib_q  <= pnib_d;
      abort_q <= abort_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    prev_q <= prev_d;
    dlt_q  <= dlt_d;
    scan_q <= scan_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    last_q <= last_d;
    ob_q   <= ob_d;
    eor_q  <= eor_d;
    eob_q  <= eob_d;
    err_q  <= err_d;
  end

  assign byte_out_o.valid        = ov_q;
  assign byte_out_o.out_byte     = ob_q;
  assign byte_out_o.end_of_run   = eor_q;
  assign byte_out_o.end_of_block = eob_q;
  assign byte_out_o.delta_error  = err_q;

endmodule

[tb/sv/tdne_tb_pkg.sv]
package tdne_tb_pkg;
  import tdne_pkg::*;

  // one coded byte as it appears on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_run;
    logic              end_of_block;
    logic              delta_error;
  } coded_byte_t;

  // Predicts the byte stream of the delta encoder and checks the bytes received
  class tdne_stream_scoreboard;
    logic [TAG_W-1:0]   prev_tag;
    bit                 half_full;
    logic [DIGIT_W-1:0] half_nibble;
    bit                 block_dropped;
    coded_byte_t        tag_bytes_q[$];
    coded_byte_t        expected_bytes_q[$];
    int unsigned        mismatches;

    function new();
      prev_tag      = '0;
      half_full     = 1'b0;
      half_nibble   = '0;
      block_dropped = 1'b0;
      mismatches    = 0;
    endfunction

    function void put_byte(logic [BYTE_W-1:0] b);
      coded_byte_t cb;
      cb = '{out_byte: b, end_of_run: 1'b0, end_of_block: 1'b0, delta_error: 1'b0};
      tag_bytes_q.push_back(cb);
    endfunction

    // high nibble first; a lone nibble waits for its partner
    function void put_nibble(logic [DIGIT_W-1:0] nib);
      if (half_full) begin
        put_byte({half_nibble, nib});
        half_full   = 1'b0;
        half_nibble = '0;
      end else begin
        half_nibble = nib;
        half_full   = 1'b1;
      end
    endfunction

    // Works out the bytes one accepted tag request causes; returns how many
    function int note_tag(logic [TAG_W-1:0] tag, bit first, bit last);
      logic [TAG_W-1:0] delta;
      logic [TAG_W-1:0] mag;
      logic [TAG_W-1:0] rest;
      logic [TAG_W-1:0] want;
      bit               neg;
      int               len;
      int               idx;
      coded_byte_t      err_byte;

      tag_bytes_q.delete();
      if (first) begin
        // block start: header of 8 bytes, MSB first
        half_full     = 1'b0;
        half_nibble   = '0;
        block_dropped = 1'b0;
        for (int i = HDR_BYTES - 1; i >= 0; i--) put_byte(tag[8*i +: 8]);
        prev_tag = tag;
      end else begin
        if (block_dropped) return 0;
        delta    = tag - prev_tag;
        prev_tag = tag;
        neg      = delta[TAG_W-1];
        mag      = neg ? (~delta + 64'd1) : delta;
        // out of range: single error byte, block dropped
        if (mag > DELTA_LIMIT) begin
          block_dropped = 1'b1;
          half_full     = 1'b0;
          half_nibble   = '0;
          err_byte = '{out_byte: '0, end_of_run: 1'b1, end_of_block: 1'b1, delta_error: 1'b1};
          expected_bytes_q.push_back(err_byte);
          return 1;
        end
        // fewest nibbles whose top bit still carries the sign
        len = 15;
        for (int k = 15; k >= 1; k--) begin
          rest = delta >> (4*k - 1);
          want = neg ? ({TAG_W{1'b1}} >> (4*k - 1)) : '0;
          if (rest == want) len = k;
        end
        put_nibble(len[DIGIT_W-1:0]);
        for (int k = len - 1; k >= 0; k--) put_nibble(delta[4*k +: 4]);
      end

      // end of block flushes a waiting half byte
      if (last && half_full) begin
        put_byte({half_nibble, 4'h0});
        half_full   = 1'b0;
        half_nibble = '0;
      end
      if (tag_bytes_q.size() > 0) begin
        idx = tag_bytes_q.size() - 1;
        tag_bytes_q[idx].end_of_run = 1'b1;
        if (last) tag_bytes_q[idx].end_of_block = 1'b1;
      end
      foreach (tag_bytes_q[i]) expected_bytes_q.push_back(tag_bytes_q[i]);
      return tag_bytes_q.size();
    endfunction

    // Compares one accepted byte with the oldest expected one
    function void check_byte(coded_byte_t got);
      coded_byte_t exp_b;
      if (expected_bytes_q.size() == 0) begin
        $error("unexpected byte %h (eor %0b eob %0b err %0b)", got.out_byte,
               got.end_of_run, got.end_of_block, got.delta_error);
        mismatches++;
        return;
      end
      exp_b = expected_bytes_q.pop_front();
      if (got.out_byte !== exp_b.out_byte) begin
        $error("out_byte: expected %h, actual %h", exp_b.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.end_of_run !== exp_b.end_of_run) begin
        $error("end_of_run: expected %0b, actual %0b", exp_b.end_of_run, got.end_of_run);
        mismatches++;
      end
      if (got.end_of_block !== exp_b.end_of_block) begin
        $error("end_of_block: expected %0b, actual %0b", exp_b.end_of_block,
               got.end_of_block);
        mismatches++;
      end
      if (got.delta_error !== exp_b.delta_error) begin
        $error("delta_error: expected %0b, actual %0b", exp_b.delta_error, got.delta_error);
        mismatches++;
      end
    endfunction

    // Failures so far, counting bytes that never came
    function int unsigned close();
      if (expected_bytes_q.size() != 0) begin
        $error("%0d expected bytes never arrived", expected_bytes_q.size());
        mismatches += expected_bytes_q.size();
      end
      return mismatches;
    endfunction
  endclass

endpackage

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdne_pkg::*;
  import tdne_tb_pkg::*;

  localparam logic [TAG_W-1:0] TAG_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [TAG_W-1:0] TAG_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned      STALL_LIMIT = 4000;
  localparam int unsigned      HOLD_LEN    = 300;
  localparam int unsigned      TAIL_LEN    = 80;

  logic clk_i;
  logic rst_ni;

  tdne_tag_if  tag_if ();
  tdne_byte_if byte_if ();

  timestamp_delta_nibble_encoder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_in_i   (tag_if),
    .byte_out_o (byte_if)
  );

  tdne_stream_scoreboard sb = new();

  int unsigned      tag_gap_pct;
  int unsigned      byte_stall_pct;
  int unsigned      hold_cycles;
  int unsigned      coded_tags;
  logic [TAG_W-1:0] cur_tag;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // accepted requests feed the predictor, accepted bytes are checked
  always @(posedge clk_i) begin
    if (rst_ni && tag_if.valid && tag_if.ready) begin
      if (sb.note_tag(tag_if.timestamp, tag_if.first_of_block, tag_if.last_of_block) > 0)
        coded_tags++;
    end
    if (rst_ni && byte_if.valid && byte_if.ready)
      sb.check_byte('{out_byte: byte_if.out_byte, end_of_run: byte_if.end_of_run,
                      end_of_block: byte_if.end_of_block, delta_error: byte_if.delta_error});
  end

  // byte receiver: random stalls, or a long hold-off when asked
  initial begin
    byte_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        byte_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        byte_if.ready <= ($urandom_range(99) >= byte_stall_pct);
      end
    end
  end

  // watchdog on cycles in which neither a request nor a byte is taken
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((tag_if.valid && tag_if.ready) || (byte_if.valid && byte_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one tag request, after a random gap
  task automatic send_tag(input logic [TAG_W-1:0] tag, input bit first, input bit last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tag_gap_pct && gap < 40) gap++;
    if (gap != 0) begin
      tag_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tag_if.valid          <= 1'b1;
    tag_if.timestamp      <= tag;
    tag_if.first_of_block <= first;
    tag_if.last_of_block  <= last;
    @(posedge clk_i);
    while (!tag_if.ready) @(posedge clk_i);
  endtask

  task automatic start_block(input logic [TAG_W-1:0] tag, input bit last);
    cur_tag = tag;
    send_tag(cur_tag, 1'b1, last);
  endtask

  task automatic step_tag(input logic [TAG_W-1:0] delta, input bit last);
    cur_tag = cur_tag + delta;
    send_tag(cur_tag, 1'b0, last);
  endtask

  // stop offering and let every expected byte arrive
  task automatic drain_bytes();
    tag_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_bytes_q.size() != 0) @(posedge clk_i);
  endtask

  // mostly small deltas, some wide ones, a few right at the limit
  function automatic logic [TAG_W-1:0] pick_delta();
    int unsigned      w;
    logic [TAG_W-1:0] d;
    w = ($urandom_range(3) == 0) ? $urandom_range(54, 1) : $urandom_range(16, 1);
    d = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
    if ($urandom_range(19) == 0) d = DELTA_LIMIT - 64'd1 + 64'($urandom_range(2));
    if ($urandom_range(1) != 0) d = ~d + 64'd1;
    return d;
  endfunction

  // random blocks until enough coded tags have gone in
  task automatic run_random_blocks(input int unsigned n_tags);
    int unsigned goal;
    int unsigned blk_len;
    int unsigned kind;
    goal = coded_tags + n_tags;
    while (coded_tags < goal) begin
      blk_len = $urandom_range(12, 1);
      kind    = $urandom_range(99);
      start_block({$urandom, $urandom}, (blk_len == 1) && (kind < 80));
      for (int i = 1; i < blk_len; i++) begin
        if (kind >= 90 && i == 1) begin
          // wild jump, almost always out of range
          cur_tag = {$urandom, $urandom};
          send_tag(cur_tag, 1'b0, 1'b0);
        end else begin
          // unfinished blocks never see last_of_block
          step_tag(pick_delta(), (i == blk_len - 1) && (kind < 80));
        end
      end
    end
  endtask

  // stimulus
  initial begin
    tag_if.valid          <= 1'b0;
    tag_if.timestamp      <= '0;
    tag_if.first_of_block <= 1'b0;
    tag_if.last_of_block  <= 1'b0;
    tag_gap_pct    = 30;
    byte_stall_pct = 53;
    hold_cycles    = 0;
    coded_tags     = 0;
    cur_tag        = '0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: length boundaries, limits, errors, dropped blocks, flushes
    start_block(TAG_MIN, 1'b0);
    step_tag(64'd0, 1'b0);
    step_tag(64'd1, 1'b0);
    step_tag(-64'd1, 1'b0);
    step_tag(64'd7, 1'b0);
    step_tag(-64'd8, 1'b0);
    step_tag(64'd8, 1'b0);
    step_tag(-64'd9, 1'b0);
    step_tag(DELTA_LIMIT, 1'b0);
    step_tag(~DELTA_LIMIT + 64'd1, 1'b0);
    step_tag(64'd8, 1'b0);
    step_tag(DELTA_LIMIT + 64'd1, 1'b0);
    step_tag(64'd3, 1'b1);
    step_tag(64'd5, 1'b0);
    start_block(TAG_MAX, 1'b1);
    start_block(TAG_MAX, 1'b0);
    step_tag(64'd1, 1'b0);
    step_tag(64'd16, 1'b0);
    step_tag(64'd0, 1'b1);
    start_block(64'h0123_4567_89AB_CDEF, 1'b0);
    step_tag(~(DELTA_LIMIT + 64'd1) + 64'd1, 1'b1);
    start_block(64'd0, 1'b0);
    step_tag(64'd8, 1'b0);
    start_block(64'hFEDC_BA98_7654_3210, 1'b1);
    drain_bytes();

    // sender idles more lightly than the receiver
    run_random_blocks(150);
    drain_bytes();

    // roles swapped; receiver holds off while requests keep coming
    tag_gap_pct    = 53;
    byte_stall_pct = 30;
    hold_cycles    = HOLD_LEN;
    run_random_blocks(150);
    drain_bytes();

    // no idling on either side
    tag_gap_pct    = 0;
    byte_stall_pct = 0;
    run_random_blocks(150);
    drain_bytes();

    repeat (TAIL_LEN) @(posedge clk_i);
    if (sb.close() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
